@@ sv/signed_binary_to_decimal_ascii_core_defines.svh @@
// Assertion macros for the checker of the decimal text converter.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBDA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Converter check failed in the same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define SBDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Converter check failed in the following cycle.");

`endif

@@ sv/sbda_pkg.sv @@
// Shared constants and the digit correction function of the decimal text converter.
package sbda_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int CHAR_WIDTH = 8;

   localparam logic [CHAR_WIDTH-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;

   function automatic logic [3:0] bcd_adjust(input logic [3:0] digit);
      return (digit >= 4'd5) ? (digit + 4'd3) : digit;
   endfunction

endpackage

@@ sv/signed_binary_to_decimal_ascii_core.sv @@
// Signed binary integer to decimal ASCII text converter, one character per response.
//
// Each request carries a two's complement integer whose low INPUT_WIDTH bits are
// used. The core takes the magnitude, converts it bit-serially with a shift-and-add-3
// BCD register (one input bit per cycle), then shifts the BCD register out one digit
// per cycle while the response side does not stall, skipping leading zeros, after an
// optional minus sign. A request keeps the core busy through its conversion, the minus
// sign if any and every digit, including any stalls of the response side. rsp_last marks
// the final character of each number. A new request is taken once the final
// character has been loaded into the output register, even while that character is
// still waiting to be taken.
module signed_binary_to_decimal_ascii_core
   import sbda_pkg::*;
#(
   parameter int INPUT_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAR_WIDTH-1:0]  rsp_out_char,
   output logic                   rsp_last
);

   localparam int NUM_DIGITS = (INPUT_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_WIDTH = 4 * NUM_DIGITS;
   localparam int BIT_CNT_WIDTH = $clog2(INPUT_WIDTH);
   localparam int DIG_CNT_WIDTH = $clog2(NUM_DIGITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type                state_ff;
   logic [INPUT_WIDTH-1:0]   mag_ff;
   logic                     neg_ff;
   logic [BCD_WIDTH-1:0]     bcd_ff;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff;
   logic [DIG_CNT_WIDTH-1:0] dig_cnt_ff;
   logic                     seen_ff;
   logic                     rsp_valid_ff;
   logic [CHAR_WIDTH-1:0]    rsp_char_ff;
   logic                     rsp_last_ff;

   logic [INPUT_WIDTH-1:0]   value_bits;
   logic [INPUT_WIDTH-1:0]   mag_in;
   logic [BCD_WIDTH-1:0]     bcd_adj;
   logic [3:0]               top_digit;
   logic                     out_free;
   logic                     show_digit;
   logic                     load_char;

   assign value_bits = req_value[INPUT_WIDTH-1:0];
   assign mag_in = value_bits[INPUT_WIDTH-1] ? (~value_bits + INPUT_WIDTH'(1)) : value_bits;
   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign show_digit = (top_digit != 4'd0) || seen_ff || (dig_cnt_ff == '0);
   assign load_char = out_free && ((state_ff == ST_SIGN) || (state_ff == ST_EMIT && show_digit));

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         bcd_adj[4*d +: 4] = bcd_adjust(bcd_ff[4*d +: 4]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_char) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  mag_ff     <= mag_in;
                  neg_ff     <= value_bits[INPUT_WIDTH-1];
                  bcd_ff     <= '0;
                  bit_cnt_ff <= BIT_CNT_WIDTH'(INPUT_WIDTH - 1);
                  state_ff   <= ST_CONV;
               end
            end
            ST_CONV: begin
               mag_ff <= {mag_ff[INPUT_WIDTH-2:0], 1'b0};
               bcd_ff <= {bcd_adj[BCD_WIDTH-2:0], mag_ff[INPUT_WIDTH-1]};
               if (bit_cnt_ff == '0) begin
                  dig_cnt_ff <= DIG_CNT_WIDTH'(NUM_DIGITS - 1);
                  seen_ff    <= 1'b0;
                  state_ff   <= neg_ff ? ST_SIGN : ST_EMIT;
               end else begin
                  bit_cnt_ff <= bit_cnt_ff - 1'b1;
               end
            end
            ST_SIGN: begin
               if (out_free) begin
                  rsp_char_ff  <= CH_MINUS;
                  rsp_last_ff  <= 1'b0;
                  state_ff     <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!show_digit) begin
                  bcd_ff     <= {bcd_ff[BCD_WIDTH-5:0], 4'd0};
                  dig_cnt_ff <= dig_cnt_ff - 1'b1;
               end else if (out_free) begin
                  rsp_char_ff  <= CH_ZERO | {4'd0, top_digit};
                  rsp_last_ff  <= (dig_cnt_ff == '0);
                  seen_ff      <= 1'b1;
                  bcd_ff       <= {bcd_ff[BCD_WIDTH-5:0], 4'd0};
                  if (dig_cnt_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     dig_cnt_ff <= dig_cnt_ff - 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last = rsp_last_ff;

endmodule

@@ sv/sbda_checker.sv @@
// Port-level checker for the decimal text converter and its bind to the top level.
`include "signed_binary_to_decimal_ascii_core_defines.svh"

module sbda_checker
   import sbda_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [CHAR_WIDTH-1:0] rsp_out_char,
   input logic                  rsp_last
);

   // A stalled character stays on the port unchanged.
   `SBDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_char) && $stable(rsp_last))

   // Only a minus sign that is never final, or a decimal digit, is ever shown.
   `SBDA_ASSERT_SAME(a_rsp_charset, clock, reset, rsp_valid, (rsp_out_char == CH_MINUS && !rsp_last) || (rsp_out_char >= CH_ZERO && rsp_out_char <= CH_NINE))

   // The digit right after a minus sign is never a leading zero.
   `SBDA_ASSERT_NEXT(a_no_zero_after_sign, clock, reset, rsp_valid && !rsp_stall && rsp_out_char == CH_MINUS, !(rsp_valid && rsp_out_char == CH_ZERO))

   // A request that was just taken keeps the core busy in the next cycle.
   `SBDA_ASSERT_NEXT(a_busy_after_request, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind signed_binary_to_decimal_ascii_core sbda_checker u_sbda_checker (.*);
